// ===== design/stct_pkg.sv =====
package stct_pkg;

  localparam int MODE_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_FIND   = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOWN_CHK,
    ST_DOWN_CMP,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_BACK_CHK,
    ST_BACK_CMP,
    ST_FINISH,
    ST_DROP
  } state_e;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_t;

endpackage

// ===== design/stct_if.sv =====
interface stct_req_if
  import stct_pkg::*;
#(
  parameter int COORD_WIDTH  = 8,
  parameter int HANDLE_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [COORD_WIDTH-1:0]  key_above;
  logic [COORD_WIDTH-1:0]  key_north;
  logic [COORD_WIDTH-1:0]  key_east;
  logic [HANDLE_WIDTH-1:0] object_handle;

  modport source (
    output valid, mode, key_above, key_north, key_east, object_handle,
    input  ready
  );
  modport sink (
    input  valid, mode, key_above, key_north, key_east, object_handle,
    output ready
  );
endinterface

interface stct_rsp_if #(
  parameter int HANDLE_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic [HANDLE_WIDTH-1:0] match_handle;
  logic                    last_match;
  logic                    full_drop;

  modport source (
    output valid, found, match_handle, last_match, full_drop,
    input  ready
  );
  modport sink (
    input  valid, found, match_handle, last_match, full_drop,
    output ready
  );
endinterface

// ===== design/stct_table.sv =====
module stct_table #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/stct_cmp.sv =====
module stct_cmp
  import stct_pkg::*;
#(
  parameter int KEY_WIDTH = 24
) (
  input  logic [KEY_WIDTH-1:0] entry_i,
  input  logic [KEY_WIDTH-1:0] target_i,
  output cmp_t                 res_o
);

  assign res_o.gt = (entry_i > target_i);
  assign res_o.eq = (entry_i == target_i);

endmodule

// ===== design/sorted_table_cursor_lookup.sv =====
// Channel  Dir  Transfer payload
// req_i    in   mode, key_above, key_north, key_east, object_handle
// rsp_o    out  found, match_handle, last_match, full_drop
//
// Clear and append act on acceptance; a dropped append goes through a drop state to load its result.
// Find accepts the key, then reads each table entry in an address state and a compare state
// on the single read port; each walk that stops at a table bound, the step down from the end
// and the final result load each take a state of their own; walks track cursor distance.
// Reset clears control state only; table contents are undefined until appended.
// A stalled result register holds the sequencer at its next result.
module sorted_table_cursor_lookup
  import stct_pkg::*;
#(
  parameter int TABLE_DEPTH  = 64,
  parameter int COORD_WIDTH  = 8,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stct_req_if.sink    req_i,
  stct_rsp_if.source  rsp_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = 3 * COORD_WIDTH;
  localparam int EW = KW + HANDLE_WIDTH;

  state_e                  state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           cursor_q, cursor_d;
  logic [KW-1:0]           target_q, target_d;
  logic                    pend_q, pend_d;
  logic [HANDLE_WIDTH-1:0] pend_handle_q, pend_handle_d;

  logic                    out_valid_q, out_valid_d;
  logic                    out_found_q, out_found_d;
  logic [HANDLE_WIDTH-1:0] out_handle_q, out_handle_d;
  logic                    out_last_q, out_last_d;
  logic                    out_drop_q, out_drop_d;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [EW-1:0]           mem_wdata;
  logic                    mem_re;
  logic [AW-1:0]           mem_raddr;
  logic [EW-1:0]           mem_rdata;

  logic [KW-1:0]           in_key;
  logic [KW-1:0]           rd_key;
  logic [HANDLE_WIDTH-1:0] rd_handle;
  logic [CW-1:0]           cursor_dec;
  logic                    out_free;
  cmp_t                    cmp;

  assign in_key     = {req_i.key_above, req_i.key_north, req_i.key_east};
  assign rd_key     = mem_rdata[EW-1 -: KW];
  assign rd_handle  = mem_rdata[HANDLE_WIDTH-1:0];
  assign cursor_dec = cursor_q - CW'(1);
  assign out_free   = !out_valid_q || rsp_o.ready;

  stct_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (EW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  stct_cmp #(
    .KEY_WIDTH (KW)
  ) u_cmp (
    .entry_i  (rd_key),
    .target_i (target_q),
    .res_o    (cmp)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    cursor_d      = cursor_q;
    target_d      = target_q;
    pend_d        = pend_q;
    pend_handle_d = pend_handle_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_found_d   = out_found_q;
    out_handle_d  = out_handle_q;
    out_last_d    = out_last_q;
    out_drop_d    = out_drop_q;
    mem_we        = 1'b0;
    mem_waddr     = count_q[AW-1:0];
    mem_wdata     = {in_key, req_i.object_handle};
    mem_re        = 1'b0;
    mem_raddr     = cursor_q[AW-1:0];
    req_i.ready   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          unique case (mode_e'(req_i.mode))
            MODE_CLEAR: begin
              count_d  = '0;
              cursor_d = '0;
            end
            MODE_APPEND: begin
              if (count_q == CW'(TABLE_DEPTH)) begin
                state_d = ST_DROP;
              end else begin
                mem_we   = 1'b1;
                count_d  = count_q + CW'(1);
                cursor_d = count_q + CW'(1);
              end
            end
            MODE_FIND: begin
              target_d = in_key;
              if (cursor_q > count_q) begin
                cursor_d = count_q;
              end
              state_d = ST_DOWN_CHK;
            end
            default: ;
          endcase
        end
      end
      ST_DOWN_CHK: begin
        priority if (cursor_q == '0) begin
          state_d = ST_UP_CHK;
        end else if (cursor_q == count_q) begin
          cursor_d = cursor_dec;
        end else begin
          mem_re  = 1'b1;
          state_d = ST_DOWN_CMP;
        end
      end
      ST_DOWN_CMP: begin
        if (cmp.gt) begin
          cursor_d = cursor_dec;
          state_d  = ST_DOWN_CHK;
        end else begin
          state_d = ST_UP_CHK;
        end
      end
      ST_UP_CHK: begin
        if (cursor_q == count_q) begin
          state_d = ST_BACK_CHK;
        end else begin
          mem_re  = 1'b1;
          state_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (!cmp.gt) begin
          cursor_d = cursor_q + CW'(1);
          state_d  = ST_UP_CHK;
        end else begin
          state_d = ST_BACK_CHK;
        end
      end
      ST_BACK_CHK: begin
        if (cursor_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          cursor_d  = cursor_dec;
          mem_re    = 1'b1;
          mem_raddr = cursor_dec[AW-1:0];
          state_d   = ST_BACK_CMP;
        end
      end
      ST_BACK_CMP: begin
        if (!cmp.eq) begin
          state_d = ST_FINISH;
        end else if (!pend_q || out_free) begin
          // previous match is not the last one
          if (pend_q) begin
            out_valid_d  = 1'b1;
            out_found_d  = 1'b1;
            out_handle_d = pend_handle_q;
            out_last_d   = 1'b0;
            out_drop_d   = 1'b0;
          end
          pend_d        = 1'b1;
          pend_handle_d = rd_handle;
          state_d       = ST_BACK_CHK;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_found_d  = pend_q;
          out_handle_d = pend_q ? pend_handle_q : '0;
          out_last_d   = 1'b1;
          out_drop_d   = 1'b0;
          pend_d       = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      ST_DROP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_found_d  = 1'b0;
          out_handle_d = '0;
          out_last_d   = 1'b0;
          out_drop_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q      <= target_d;
    pend_handle_q <= pend_handle_d;
    out_found_q   <= out_found_d;
    out_handle_q  <= out_handle_d;
    out_last_q    <= out_last_d;
    out_drop_q    <= out_drop_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.found        = out_found_q;
  assign rsp_o.match_handle = out_handle_q;
  assign rsp_o.last_match   = out_last_q;
  assign rsp_o.full_drop    = out_drop_q;

`ifndef NO_ASSERTIONS
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q)
    else $error("cursor beyond table end");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond depth");

  a_no_pending_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_q)
    else $error("pending match left in idle");

  a_drop_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_drop_q |-> !out_found_q && !out_last_q)
    else $error("drop result carries match fields");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp_o.ready |=> out_valid_q && $stable(out_handle_q))
    else $error("stalled result changed");
`endif

endmodule

// ===== tb/sorted_table_cursor_lookup_test.sv =====
`timescale 1ns / 100ps

module sorted_table_cursor_lookup_test
  import stct_pkg::*;
;

  localparam int DEPTH = 64;
  localparam int CW    = 8;
  localparam int HW    = 16;
  localparam int KW    = 3 * CW;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [KW-1:0]     KEY_MAX     = {KW{1'b1}};

  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 50;
  localparam int ITEM_TARGET = 170;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CW-1:0]     above;
    logic [CW-1:0]     north;
    logic [CW-1:0]     east;
    logic [HW-1:0]     handle;
    logic              hold;
  } lookup_req_t;

  typedef struct packed {
    logic          found;
    logic [HW-1:0] handle;
    logic          last;
    logic          drop;
  } lookup_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              drv_valid     = 1'b0;
  logic [MODE_W-1:0] drv_mode      = '0;
  logic [CW-1:0]     drv_above     = '0;
  logic [CW-1:0]     drv_north     = '0;
  logic [CW-1:0]     drv_east      = '0;
  logic [HW-1:0]     drv_handle    = '0;
  logic              drv_rsp_ready = 1'b0;

  stct_req_if #(.COORD_WIDTH(CW), .HANDLE_WIDTH(HW)) req_if ();
  stct_rsp_if #(.HANDLE_WIDTH(HW)) rsp_if ();

  assign req_if.valid         = drv_valid;
  assign req_if.mode          = drv_mode;
  assign req_if.key_above     = drv_above;
  assign req_if.key_north     = drv_north;
  assign req_if.key_east      = drv_east;
  assign req_if.object_handle = drv_handle;
  assign rsp_if.ready         = drv_rsp_ready;

  sorted_table_cursor_lookup #(
    .TABLE_DEPTH (DEPTH),
    .COORD_WIDTH (CW),
    .HANDLE_WIDTH(HW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  lookup_req_t pending_lookups[$];
  lookup_rsp_t expected_hits[$];

  logic [KW-1:0] tbl_key[DEPTH];
  logic [HW-1:0] tbl_handle[DEPTH];
  int unsigned   tbl_count  = 0;
  int unsigned   tbl_cursor = 0;

  int error_count = 0;
  int stim_items  = 0;
  int idle_cycles = 0;

  function automatic void enqueue_lookup(logic [MODE_W-1:0] mode, logic [KW-1:0] key,
                                         logic [HW-1:0] handle, logic hold);
    lookup_req_t r;
    r.mode   = mode;
    r.above  = key[KW-1 -: CW];
    r.north  = key[2*CW-1 -: CW];
    r.east   = key[CW-1:0];
    r.handle = handle;
    r.hold   = hold;
    pending_lookups.push_back(r);
    if (mode != MODE_UNUSED) stim_items++;
  endfunction

  function automatic void push_hit(logic found, logic [HW-1:0] handle, logic last,
                                   logic drop);
    lookup_rsp_t e;
    e.found  = found;
    e.handle = handle;
    e.last   = last;
    e.drop   = drop;
    expected_hits.push_back(e);
  endfunction

  function automatic void predict_lookup(lookup_req_t r);
    logic [KW-1:0] target;
    logic [HW-1:0] hits[$];
    target = {r.above, r.north, r.east};
    case (r.mode)
      MODE_CLEAR: begin
        tbl_count  = 0;
        tbl_cursor = 0;
      end
      MODE_APPEND: begin
        if (tbl_count >= DEPTH) begin
          push_hit(1'b0, '0, 1'b0, 1'b1);
        end else begin
          tbl_key[tbl_count]    = target;
          tbl_handle[tbl_count] = r.handle;
          tbl_count++;
          tbl_cursor = tbl_count;
        end
      end
      MODE_FIND: begin
        if (tbl_cursor > tbl_count) tbl_cursor = tbl_count;
        while (tbl_cursor != 0 &&
               (tbl_cursor == tbl_count || tbl_key[tbl_cursor] > target))
          tbl_cursor--;
        while (tbl_cursor != tbl_count && tbl_key[tbl_cursor] <= target)
          tbl_cursor++;
        while (tbl_cursor != 0 && hits.size() < DEPTH) begin
          tbl_cursor--;
          if (tbl_key[tbl_cursor] != target) break;
          hits.push_back(tbl_handle[tbl_cursor]);
        end
        if (hits.size() == 0) begin
          push_hit(1'b0, '0, 1'b1, 1'b0);
        end else begin
          foreach (hits[i]) push_hit(1'b1, hits[i], i == hits.size() - 1, 1'b0);
        end
      end
      default: ;
    endcase
  endfunction

  // sender: bursts with random gaps, optional hold until drained
  logic req_taken = 1'b0;
  int   burst_left = 1;
  int   gap_left   = 0;
  lookup_req_t next_req;

  always @(negedge clk_i) begin
    if (rst_ni && (!drv_valid || req_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        drv_valid <= 1'b0;
      end else if (pending_lookups.size() != 0 &&
                   !(pending_lookups[0].hold && expected_hits.size() != 0)) begin
        next_req = pending_lookups.pop_front();
        drv_mode   <= next_req.mode;
        drv_above  <= next_req.above;
        drv_north  <= next_req.north;
        drv_east   <= next_req.east;
        drv_handle <= next_req.handle;
        drv_valid  <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall pattern, redrawn whenever stall_phase[5:0] is zero
  logic [15:0] stall_word  = 16'hFFFF;
  logic [31:0] stall_phase = '0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_phase[5:0] == 6'd0) begin
        case ($urandom_range(0, 3))
          0: stall_word = 16'hFFFF;
          1: stall_word = 16'($urandom);
          2: stall_word = 16'($urandom | $urandom);
          default: stall_word = 16'h00FF;
        endcase
      end
      drv_rsp_ready <= stall_word[stall_phase[3:0]];
      stall_phase++;
    end
  end

  // monitor: predicts on request transfers, checks response transfers
  lookup_req_t seen_req;
  lookup_rsp_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_taken <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        seen_req.mode   = req_if.mode;
        seen_req.above  = req_if.key_above;
        seen_req.north  = req_if.key_north;
        seen_req.east   = req_if.key_east;
        seen_req.handle = req_if.object_handle;
        seen_req.hold   = 1'b0;
        predict_lookup(seen_req);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_hits.size() == 0) begin
          $error("unexpected result: found=%0d match_handle=%0h last_match=%0d full_drop=%0d",
                 rsp_if.found, rsp_if.match_handle, rsp_if.last_match, rsp_if.full_drop);
          error_count++;
        end else begin
          want = expected_hits.pop_front();
          if (rsp_if.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, rsp_if.found);
            error_count++;
          end
          if (rsp_if.match_handle !== want.handle) begin
            $error("match_handle: expected %0h, got %0h", want.handle, rsp_if.match_handle);
            error_count++;
          end
          if (rsp_if.last_match !== want.last) begin
            $error("last_match: expected %0d, got %0d", want.last, rsp_if.last_match);
            error_count++;
          end
          if (rsp_if.full_drop !== want.drop) begin
            $error("full_drop: expected %0d, got %0d", want.drop, rsp_if.full_drop);
            error_count++;
          end
        end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  logic [KW-1:0] seq_keys[$];
  logic [KW-1:0] key;
  logic [KW-1:0] target;
  int            n_app;
  int            n_find;
  int            step;
  int            sel;
  bit            full_done;

  initial begin
    // empty table, ignored mode, duplicates, extremes
    enqueue_lookup(MODE_FIND, 24'h000000, 16'h0000, 1'b0);
    enqueue_lookup(MODE_UNUSED, 24'h123456, 16'hBEEF, 1'b0);
    enqueue_lookup(MODE_APPEND, 24'h000000, 16'h0000, 1'b0);
    enqueue_lookup(MODE_APPEND, 24'h000000, 16'hFFFF, 1'b0);
    enqueue_lookup(MODE_APPEND, 24'h010203, 16'h1234, 1'b0);
    enqueue_lookup(MODE_APPEND, 24'h7F80FF, 16'hA5A5, 1'b0);
    enqueue_lookup(MODE_APPEND, 24'h7F80FF, 16'h5A5A, 1'b0);
    enqueue_lookup(MODE_APPEND, 24'h7F80FF, 16'h0001, 1'b0);
    enqueue_lookup(MODE_APPEND, 24'hFFFFFF, 16'hFFFF, 1'b0);
    enqueue_lookup(MODE_FIND, 24'hFFFFFF, 16'h0000, 1'b0);
    enqueue_lookup(MODE_FIND, 24'h000000, 16'hFFFF, 1'b0);
    enqueue_lookup(MODE_FIND, 24'h7F80FF, 16'h0000, 1'b0);
    enqueue_lookup(MODE_FIND, 24'h7F8100, 16'h0000, 1'b0);
    enqueue_lookup(MODE_FIND, 24'h000001, 16'h0000, 1'b0);
    enqueue_lookup(MODE_FIND, 24'h7F80FF, 16'h0000, 1'b1);
    enqueue_lookup(MODE_UNUSED, 24'hFFFFFF, 16'hFFFF, 1'b0);
    enqueue_lookup(MODE_CLEAR, 24'hFFFFFF, 16'hFFFF, 1'b0);
    enqueue_lookup(MODE_FIND, 24'hFFFFFF, 16'h0000, 1'b0);
    // out of order table
    enqueue_lookup(MODE_APPEND, 24'h800000, 16'h8000, 1'b0);
    enqueue_lookup(MODE_APPEND, 24'h100000, 16'h0100, 1'b0);
    enqueue_lookup(MODE_FIND, 24'h100000, 16'h0000, 1'b0);
    enqueue_lookup(MODE_FIND, 24'h800000, 16'h0000, 1'b0);
    enqueue_lookup(MODE_CLEAR, 24'h000000, 16'h0000, 1'b0);

    full_done = 1'b0;
    while (stim_items < ITEM_TARGET) begin
      if ($urandom_range(0, 4) != 0) begin
        enqueue_lookup(MODE_CLEAR, KW'($urandom_range(0, KEY_MAX)), HW'($urandom), 1'b0);
        seq_keys.delete();
      end
      if (!full_done && stim_items > 60) begin
        n_app     = DEPTH + $urandom_range(1, 3);
        full_done = 1'b1;
      end else begin
        n_app = $urandom_range(1, 10);
      end
      case ($urandom_range(0, 5))
        0: key = '0;
        1: key = KW'(KEY_MAX - $urandom_range(0, 40));
        default: key = KW'($urandom_range(0, KEY_MAX));
      endcase
      for (int i = 0; i < n_app; i++) begin
        step = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 600) : $urandom_range(0, 2);
        key  = (key <= KEY_MAX - step) ? KW'(key + step) : KEY_MAX;
        enqueue_lookup(MODE_APPEND, key, HW'($urandom), 1'b0);
        seq_keys.push_back(key);
        if ($urandom_range(0, 19) == 0) begin
          target = KW'($urandom_range(0, KEY_MAX));
          enqueue_lookup(MODE_APPEND, target, HW'($urandom), 1'b0);
          seq_keys.push_back(target);
        end
      end
      n_find = $urandom_range(2, 6);
      for (int j = 0; j < n_find; j++) begin
        sel = $urandom_range(0, 9);
        if (seq_keys.size() == 0 || sel >= 8) begin
          target = KW'($urandom_range(0, KEY_MAX));
        end else begin
          target = seq_keys[$urandom_range(0, seq_keys.size() - 1)];
          if (sel == 6) target = target + KW'(1);
          if (sel == 7) target = target - KW'(1);
        end
        enqueue_lookup(MODE_FIND, target, HW'($urandom), $urandom_range(0, 24) == 0);
      end
      if ($urandom_range(0, 9) == 0)
        enqueue_lookup(MODE_UNUSED, KW'($urandom_range(0, KEY_MAX)), HW'($urandom), 1'b0);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_lookups.size() != 0 || drv_valid) @(posedge clk_i);
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
